>>> design/scl_pkg.sv
`default_nettype none
package scl_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_EVENTS  = 4;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_WESC  = 3'd2,
    M_QUOTE = 3'd3,
    M_QESC  = 3'd4,
    M_GT    = 3'd5,
    M_DROP  = 3'd6
  } lex_mode_t;

  typedef enum logic [3:0] {
    EV_BYTE = 4'd0,
    EV_WEND = 4'd1,
    EV_PIPE = 4'd2,
    EV_IN   = 4'd3,
    EV_OUT  = 4'd4,
    EV_APP  = 4'd5,
    EV_SEP  = 4'd6,
    EV_UNCL = 4'd7,
    EV_BESC = 4'd8,
    EV_LEND = 4'd9
  } ev_kind_t;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_PIPE = 8'h7C;

  // events caused by one input byte, in order
  typedef struct packed {
    logic [2:0]           count;
    ev_kind_t [3:0]       kind;
    logic [3:0][7:0]      ch;
  } ev_bundle_t;

  typedef struct packed {
    lex_mode_t  next;
    ev_bundle_t bundle;
  } lex_res_t;

  function automatic lex_res_t push_ev(lex_res_t r, ev_kind_t k, logic [7:0] c);
    lex_res_t o;
    o = r;
    if (o.bundle.count < 3'(MAX_EVENTS)) begin
      o.bundle.kind[o.bundle.count[1:0]] = k;
      o.bundle.ch[o.bundle.count[1:0]]   = c;
      o.bundle.count = o.bundle.count + 3'd1;
    end
    return o;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_NL) || (c == CH_SEMI) || (c == CH_NUL);
  endfunction

  // byte seen between tokens
  function automatic lex_res_t idle_byte(lex_res_t r, logic [7:0] c);
    lex_res_t o;
    o = r;
    o.next = M_IDLE;
    case (c) inside
      CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF, CH_NUL: ;
      CH_PIPE:        o = push_ev(o, EV_PIPE, 8'h00);
      CH_LT:          o = push_ev(o, EV_IN, 8'h00);
      CH_GT:          o.next = M_GT;
      CH_NL, CH_SEMI: o = push_ev(o, EV_SEP, 8'h00);
      CH_DQ:          o.next = M_QUOTE;
      CH_BSL:         o.next = M_WESC;
      default: begin
        o = push_ev(o, EV_BYTE, c);
        o.next = M_WORD;
      end
    endcase
    return o;
  endfunction

  function automatic lex_res_t lex_step(lex_mode_t mode, logic [7:0] c, logic eol);
    lex_res_t r;
    logic     valid_esc;
    r = '0;
    r.next = mode;
    valid_esc = (c == CH_BSL) || (c == CH_DQ);
    unique case (mode)
      M_WORD: begin
        if (is_delim(c)) begin
          r = push_ev(r, EV_WEND, 8'h00);
          r = idle_byte(r, c);
        end else if (c == CH_DQ) begin
          r.next = M_QUOTE;
        end else if (c == CH_BSL) begin
          r.next = M_WESC;
        end else begin
          r = push_ev(r, EV_BYTE, c);
        end
      end
      M_WESC: begin
        if (valid_esc) begin
          r = push_ev(r, EV_BYTE, c);
          r.next = M_WORD;
        end else begin
          r = push_ev(r, EV_BESC, 8'h00);
          r.next = M_DROP;
        end
      end
      M_QUOTE: begin
        if (c == CH_DQ) begin
          r.next = M_WORD;
        end else if (eol) begin
          r = push_ev(r, EV_UNCL, 8'h00);
          r.next = M_DROP;
        end else if (c == CH_BSL) begin
          r.next = M_QESC;
        end else begin
          r = push_ev(r, EV_BYTE, c);
        end
      end
      M_QESC: begin
        if (!valid_esc) begin
          r = push_ev(r, EV_BESC, 8'h00);
          r.next = M_DROP;
        end else if (eol) begin
          r = push_ev(r, EV_UNCL, 8'h00);
          r.next = M_DROP;
        end else begin
          r = push_ev(r, EV_BYTE, c);
          r.next = M_QUOTE;
        end
      end
      M_GT: begin
        if (c == CH_GT) begin
          r = push_ev(r, EV_APP, 8'h00);
          r.next = M_IDLE;
        end else begin
          r = push_ev(r, EV_OUT, 8'h00);
          r = idle_byte(r, c);
        end
      end
      M_DROP: ;
      default: r = idle_byte(r, c);
    endcase
    if (eol) begin
      case (r.next)
        M_WORD:         r = push_ev(r, EV_WEND, 8'h00);
        M_WESC:         r = push_ev(r, EV_BESC, 8'h00);
        M_QUOTE, M_QESC: r = push_ev(r, EV_UNCL, 8'h00);
        M_GT:           r = push_ev(r, EV_OUT, 8'h00);
        default: ;
      endcase
      r = push_ev(r, EV_LEND, 8'h00);
      r.next = M_IDLE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/scl_if.sv
`default_nettype none
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;
  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

interface scl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [7:0] char_out;
  logic       run_last;
  modport source (output valid, output event_kind, output char_out, output run_last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_out, input run_last,
                  output ready);
endinterface
`default_nettype wire

>>> design/scl_front.sv
`default_nettype none
module scl_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         char_in,
  input  wire logic               end_of_line,
  input  wire logic               q_full,
  output      logic               q_push,
  output      scl_pkg::ev_bundle_t q_data
);

  scl_pkg::lex_mode_t mode_r, mode_nxt;
  scl_pkg::lex_res_t  res;
  logic               accept;

  assign res      = scl_pkg::lex_step(mode_r, char_in, end_of_line);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    mode_nxt = accept ? res.next : mode_r;
  end

  // outputs: bytes that cause nothing are not queued
  always_comb begin
    q_push = accept && (res.bundle.count != 3'd0);
    q_data = res.bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= scl_pkg::M_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/scl_queue.sv
`default_nettype none
module scl_queue #(
  parameter int DEPTH = scl_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire scl_pkg::ev_bundle_t push_data,
  input  wire logic                pop,
  output      scl_pkg::ev_bundle_t head,
  output      logic                full,
  output      logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scl_pkg::ev_bundle_t     slot_r [DEPTH];
  logic [PW-1:0]           wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]           cnt_r;
  logic                    do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/scl_back.sv
`default_nettype none
module scl_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scl_pkg::ev_bundle_t head,
  input  wire logic                empty,
  output      logic                pop,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [3:0]          event_kind,
  output      logic [7:0]          char_out,
  output      logic                run_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [3:0] kind_r;
  logic [7:0] ch_r;
  logic       last_r;
  logic       load, take, is_last;

  assign load    = !valid_r || out_ready;
  assign take    = load && !empty;
  assign is_last = ({1'b0, idx_r} + 3'd1) == head.count;
  assign pop     = take && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) valid_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= head.kind[idx_r];
      ch_r   <= head.ch[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid  = valid_r;
  assign event_kind = kind_r;
  assign char_out   = ch_r;
  assign run_last   = last_r;

endmodule
`default_nettype wire

>>> design/shell_command_lexer.sv
// An accepted byte is classified by the front and written into the queue on the accept
//   edge; the back end then registers its first event into the output register.
// Throughput: one byte per cycle in while the queue is not full, one event per cycle out
//   while the sink is ready; the back end sends each event of a byte's bundle in turn.
// Reset (rst_n low, synchronous): lexer idle between tokens, queue empty, output invalid.
`default_nettype none
module shell_command_lexer #(
  parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  scl_in_if.sink    in_chan,
  scl_out_if.source out_chan
);

  // front -> queue
  logic                q_push;
  scl_pkg::ev_bundle_t q_data;
  // queue -> back
  scl_pkg::ev_bundle_t q_head;
  logic                q_full, q_empty, q_pop;

  // Front: holds the lexer mode and turns each byte transfer into a bundle of up to four
  // events. Whitespace between tokens and dropped bytes give no bundle unless they end the line.
  scl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .char_in     (in_chan.char_in),
    .end_of_line (in_chan.end_of_line),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  // Short bundle queue, so input can keep flowing while the back end
  // works through a multi-event byte or the sink stalls.
  scl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: serializes the head bundle one event per transfer into the output
  // register; run_last marks the bundle's final event.
  scl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .event_kind (out_chan.event_kind),
    .char_out   (out_chan.char_out),
    .run_last   (out_chan.run_last)
  );

endmodule
`default_nettype wire

>>> design/scl_checker.sv
`default_nettype none
module scl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] event_kind,
  input wire logic [7:0] char_out,
  input wire logic       run_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
                               $stable(char_out) && $stable(run_last))
    else $error("output changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_kind <= scl_pkg::EV_LEND)
    else $error("event kind out of range");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != scl_pkg::EV_BYTE |-> char_out == 8'h00)
    else $error("non-byte event carries a byte");

  a_lend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == scl_pkg::EV_LEND |-> run_last)
    else $error("line end not last event of its byte");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind shell_command_lexer scl_checker u_scl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .event_kind (out_chan.event_kind),
  .char_out   (out_chan.char_out),
  .run_last   (out_chan.run_last)
);
`default_nettype wire

>>> tb/tb_shell_command_lexer.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_shell_command_lexer;
  import scl_pkg::*;

  // One expected token event, in the order the lexer must emit it.
  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] ch;
    logic       last;
  } lex_event_t;

  // Directed stimulus row. n < 0: events come from the predictor;
  // otherwise the first n kinds in k are the typed-in expectation (all char 0).
  typedef struct {
    logic [7:0]      ch;
    logic            eol;
    int              n;
    logic [3:0][3:0] k;
  } dir_row_t;

  logic clk;
  logic rst_n;

  scl_in_if  in_chan ();
  scl_out_if out_chan ();

  shell_command_lexer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state and the events one byte causes.
  lex_mode_t  scan_mode = M_IDLE;
  ev_kind_t   step_kind [4];
  logic [7:0] step_ch [4];
  int         step_n;

  lex_event_t pending_events [$];
  dir_row_t   dir_rows [$];
  logic [7:0] line_q [$];

  int  errors       = 0;
  int  events_seen  = 0;
  int  live_bytes   = 0;
  int  bytes_sent   = 0;
  int  lines_sent   = 0;
  int  hold_cycles  = 0;
  bit  steady       = 1'b0;   // no sender gaps while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF, CH_NUL};
  endfunction

  task automatic emit_ev(input ev_kind_t k, input logic [7:0] c);
    if (step_n < MAX_EVENTS) begin
      step_kind[step_n] = k;
      step_ch[step_n]   = c;
      step_n++;
    end
  endtask

  // Byte arriving while between tokens.
  task automatic start_token(input logic [7:0] c);
    scan_mode = M_IDLE;
    if (!is_blank(c)) begin
      case (c)
        CH_PIPE: emit_ev(EV_PIPE, 8'h00);
        CH_LT: emit_ev(EV_IN, 8'h00);
        CH_GT: scan_mode = M_GT;   // held back, might become append
        CH_NL, CH_SEMI: emit_ev(EV_SEP, 8'h00);
        CH_DQ: scan_mode = M_QUOTE;
        CH_BSL: scan_mode = M_WESC;
        default: begin
          emit_ev(EV_BYTE, c);
          scan_mode = M_WORD;
        end
      endcase
    end
  endtask

  task automatic lex_byte_events(input logic [7:0] c, input logic eol);
    logic esc_ok;
    step_n = 0;
    esc_ok = (c == CH_BSL) || (c == CH_DQ);
    case (scan_mode)
      M_WORD: begin
        if (is_blank(c) || (c inside {CH_PIPE, CH_LT, CH_GT, CH_NL, CH_SEMI})) begin
          emit_ev(EV_WEND, 8'h00);
          start_token(c);
        end else if (c == CH_DQ) begin
          scan_mode = M_QUOTE;
        end else if (c == CH_BSL) begin
          scan_mode = M_WESC;
        end else begin
          emit_ev(EV_BYTE, c);
        end
      end
      M_WESC: begin
        if (esc_ok) begin
          emit_ev(EV_BYTE, c);
          scan_mode = M_WORD;
        end else begin
          emit_ev(EV_BESC, 8'h00);
          scan_mode = M_DROP;
        end
      end
      M_QUOTE: begin
        if (c == CH_DQ) begin
          scan_mode = M_WORD;
        end else if (eol) begin
          // last byte of the line is swallowed by the error
          emit_ev(EV_UNCL, 8'h00);
          scan_mode = M_DROP;
        end else if (c == CH_BSL) begin
          scan_mode = M_QESC;
        end else begin
          emit_ev(EV_BYTE, c);
        end
      end
      M_QESC: begin
        if (!esc_ok) begin
          emit_ev(EV_BESC, 8'h00);
          scan_mode = M_DROP;
        end else if (eol) begin
          emit_ev(EV_UNCL, 8'h00);
          scan_mode = M_DROP;
        end else begin
          emit_ev(EV_BYTE, c);
          scan_mode = M_QUOTE;
        end
      end
      M_GT: begin
        if (c == CH_GT) begin
          emit_ev(EV_APP, 8'h00);
          scan_mode = M_IDLE;
        end else begin
          emit_ev(EV_OUT, 8'h00);
          start_token(c);
        end
      end
      M_DROP: ;
      default: start_token(c);
    endcase
    // end of line closes whatever is still open, then marks the line end
    if (eol) begin
      case (scan_mode)
        M_WORD: emit_ev(EV_WEND, 8'h00);
        M_WESC: emit_ev(EV_BESC, 8'h00);
        M_QUOTE, M_QESC: emit_ev(EV_UNCL, 8'h00);
        M_GT: emit_ev(EV_OUT, 8'h00);
        default: ;
      endcase
      emit_ev(EV_LEND, 8'h00);
      scan_mode = M_IDLE;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: one byte per call, random gap first, prediction on transfer
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch, input logic eol, input int typed_n,
                           input logic [3:0][3:0] typed_k);
    int gap;
    gap = 0;
    if (!steady) begin
      case ($urandom_range(0, 9))
        6, 7, 8: gap = $urandom_range(1, 3);
        9: gap = $urandom_range(8, 25);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.char_in     <= ch;
    in_chan.end_of_line <= eol;
    do @(posedge clk); while (!in_chan.ready);
    // transfer happened at this edge
    bytes_sent++;
    lex_byte_events(ch, eol);
    if (typed_n >= 0) begin
      for (int i = 0; i < typed_n; i++)
        pending_events.push_back('{kind: ev_kind_t'(typed_k[i]), ch: 8'h00,
                                   last: (i == typed_n - 1)});
    end else begin
      for (int i = 0; i < step_n; i++)
        pending_events.push_back('{kind: step_kind[i], ch: step_ch[i],
                                   last: (i == step_n - 1)});
    end
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eol, input int n = -1,
                         input ev_kind_t k0 = EV_BYTE, input ev_kind_t k1 = EV_BYTE,
                         input ev_kind_t k2 = EV_BYTE, input ev_kind_t k3 = EV_BYTE);
    dir_row_t r;
    r.ch  = ch;
    r.eol = eol;
    r.n   = n;
    r.k   = {k3, k2, k1, k0};
    dir_rows.push_back(r);
  endtask

  // Any byte that is plain word content outside quotes.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || (c inside {CH_PIPE, CH_LT, CH_GT, CH_NL, CH_SEMI,
                                     CH_DQ, CH_BSL}));
    return c;
  endfunction

  // Random command line: mostly well-formed tokens, some noise and broken tails.
  task automatic build_line();
    int ntok;
    logic [7:0] c;
    line_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 7))
              0: begin
                // quoted section; delimiters are literal in here
                line_q.push_back(CH_DQ);
                repeat ($urandom_range(0, 3)) begin
                  if ($urandom_range(0, 4) == 0) begin
                    line_q.push_back(CH_BSL);
                    line_q.push_back($urandom_range(0, 1) ? CH_BSL : CH_DQ);
                  end else begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_DQ || c == CH_BSL);
                    line_q.push_back(c);
                  end
                end
                line_q.push_back(CH_DQ);
              end
              1: begin
                line_q.push_back(CH_BSL);
                line_q.push_back($urandom_range(0, 1) ? CH_BSL : CH_DQ);
              end
              default: line_q.push_back(word_char());
            endcase
          end
        end
        4: line_q.push_back(CH_PIPE);
        5: line_q.push_back(CH_LT);
        6: begin
          line_q.push_back(CH_GT);
          if ($urandom_range(0, 1)) line_q.push_back(CH_GT);
        end
        7: line_q.push_back($urandom_range(0, 1) ? CH_SEMI : CH_NL);
        8: begin
          case ($urandom_range(0, 5))
            0: line_q.push_back(CH_SP);
            1: line_q.push_back(CH_TAB);
            2: line_q.push_back(CH_CR);
            3: line_q.push_back(CH_VT);
            4: line_q.push_back(CH_FF);
            default: line_q.push_back(CH_NUL);
          endcase
        end
        default: line_q.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1)) line_q.push_back(CH_SP);
    end
    // broken tails: open quote, bad escape, trailing backslash
    case ($urandom_range(0, 9))
      0: begin
        line_q.push_back(CH_DQ);
        repeat ($urandom_range(0, 3)) line_q.push_back(word_char());
      end
      1: begin
        line_q.push_back(CH_BSL);
        line_q.push_back(word_char());
        repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      2: begin
        line_q.push_back(word_char());
        line_q.push_back(CH_BSL);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready pattern plus one long hold-off to back up the block
  // ---------------------------------------------------------------------
  initial begin
    bit held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && events_seen >= 150) begin
        held = 1'b1;
        hold_cycles = 300;
        out_chan.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
          end
          4, 5, 6, 7: begin
            out_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
          end
          8: begin
            out_chan.ready <= 1'b0;
            repeat ($urandom_range(5, 30)) @(posedge clk);
          end
          default: begin
            out_chan.ready <= 1'b1;
            @(posedge clk);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    lex_event_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $display("%0t: expected no event, actual kind %0d char %02h last %0b", $time,
                 out_chan.event_kind, out_chan.char_out, out_chan.run_last);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (out_chan.event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind,
                   out_chan.event_kind);
          errors++;
        end
        if (out_chan.char_out !== want.ch) begin
          $display("%0t: char_out expected %02h actual %02h", $time, want.ch,
                   out_chan.char_out);
          errors++;
        end
        if (out_chan.run_last !== want.last) begin
          $display("%0t: run_last expected %0b actual %0b", $time, want.last,
                   out_chan.run_last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.char_in     <= 8'h00;
    in_chan.end_of_line <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed rows hold only non-byte events, so char is zero.
    add_row(CH_PIPE, 1'b0, 1, EV_PIPE);                  // pipe straight after reset
    add_row(CH_LT,   1'b0, 1, EV_IN);
    add_row(8'h61,   1'b0);                              // "a" opens a word
    add_row(CH_GT,   1'b0);                              // closes it, '>' held back
    add_row(CH_GT,   1'b0, 1, EV_APP);                   // ">>" append
    add_row(8'hFF,   1'b0);                              // top byte as word content
    add_row(CH_NUL,  1'b0);                              // zero byte ends the word
    add_row(CH_SEMI, 1'b0, 1, EV_SEP);
    add_row(CH_NL,   1'b1, 2, EV_SEP, EV_LEND);
    add_row(CH_DQ,   1'b0);                              // empty quoted word
    add_row(CH_DQ,   1'b0);
    add_row(CH_SP,   1'b1, 2, EV_WEND, EV_LEND);
    add_row(CH_BSL,  1'b0);                              // bad escape, then drop
    add_row(CH_FF,   1'b0, 1, EV_BESC);
    add_row(CH_VT,   1'b1, 1, EV_LEND);
    add_row(CH_DQ,   1'b0);                              // escaped quote in quotes
    add_row(CH_BSL,  1'b0);
    add_row(CH_DQ,   1'b0);
    add_row(8'h7A,   1'b1, 2, EV_UNCL, EV_LEND);         // unclosed at line end
    add_row(CH_GT,   1'b0);                              // pending '>' then word at eol:
    add_row(8'h61,   1'b1);                              //   four events from one byte
    add_row(8'h77,   1'b0);
    add_row(CH_BSL,  1'b1, 2, EV_BESC, EV_LEND);         // trailing backslash
    add_row(CH_GT,   1'b1, 2, EV_OUT, EV_LEND);          // lone '>' flushed by eol
    add_row(CH_DQ,   1'b0);
    add_row(CH_BSL,  1'b0);
    add_row(CH_BSL,  1'b1, 2, EV_UNCL, EV_LEND);         // valid escape, but eol in quote

    foreach (dir_rows[i])
      send_byte(dir_rows[i].ch, dir_rows[i].eol, dir_rows[i].n, dir_rows[i].k);

    // Random lines; bytes swallowed after an error do not count.
    while (live_bytes < 480) begin
      build_line();
      steady = ($urandom_range(0, 2) == 0);
      foreach (line_q[i]) begin
        if (scan_mode != M_DROP || i == line_q.size() - 1) live_bytes++;
        send_byte(line_q[i], (i == line_q.size() - 1), -1, '0);
      end
      lines_sent++;
    end
    in_chan.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // catch any stray trailing events

    $display("Lexed %0d bytes: %0d directed rows and %0d random lines, %0d events checked.",
             bytes_sent, dir_rows.size(), lines_sent, events_seen);
    $display("Output side held off once for %0d cycles to back up the input.",
             hold_cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
